// File: hdl/ipth_pkg.sv
// ----------------------------------------------------------------------------
// ipth_pkg
// Shared types, protocol codes and helpers for the IP/TCP header parser.
// ----------------------------------------------------------------------------
package ipth_pkg;

  localparam logic [3:0] IP_V4 = 4'd4;
  localparam logic [3:0] IP_V6 = 4'd6;

  localparam logic [7:0] PROTO_TCP   = 8'd6;
  localparam logic [7:0] NH_HOPOPT   = 8'd0;
  localparam logic [7:0] NH_ROUTING  = 8'd43;
  localparam logic [7:0] NH_FRAGMENT = 8'd44;
  localparam logic [7:0] NH_DSTOPTS  = 8'd60;

  localparam logic [15:0] V4_MIN_LEN    = 16'd20;
  localparam logic [15:0] V6_MIN_LEN    = 16'd54;
  localparam logic [15:0] V6_HDR_LEN    = 16'd40;
  localparam logic [15:0] TCP_MIN_BYTES = 16'd14;
  localparam logic [15:0] TCP_FLAGS_POS = 16'd13;
  localparam logic [15:0] TCP_ACC_BYTES = 16'd8;
  localparam logic [15:0] OFFSET_SAT    = 16'hFFFF;
  localparam logic [3:0]  V4_MIN_IHL    = 4'd5;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_NOT_TCP = 2'd1,
    STATUS_FAIL    = 2'd2
  } status_t;

  // per-packet parse state
  typedef struct packed {
    logic [15:0] byte_position;
    logic [3:0]  ip_version;
    logic [3:0]  header_words;
    logic [7:0]  first_proto_byte;
    logic [15:0] total_length_field;
    logic [7:0]  next_header;
    logic [15:0] transport_offset;
    logic        chain_done;
    logic        ext_pending;
    logic [63:0] src_hi;
    logic [63:0] src_lo;
    logic [63:0] dst_hi;
    logic [63:0] dst_lo;
    logic [63:0] tcp_field_accum;
    logic [7:0]  flags_hold;
  } pkt_state_t;

  // one finished packet summary
  typedef struct packed {
    status_t     status;
    logic        is_ipv6;
    logic [63:0] src_addr_hi;
    logic [63:0] src_addr_lo;
    logic [63:0] dst_addr_hi;
    logic [63:0] dst_addr_lo;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [31:0] seq_number;
    logic [7:0]  tcp_flags;
    logic [15:0] ip_length;
  } pkt_result_t;

  function automatic logic is_len_ext(input logic [7:0] nh);
    return (nh == NH_HOPOPT) || (nh == NH_ROUTING) || (nh == NH_DSTOPTS);
  endfunction

  function automatic logic is_skippable(input logic [7:0] nh);
    return is_len_ext(nh) || (nh == NH_FRAGMENT);
  endfunction

  function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [16:0] b);
    logic [16:0] s;
    s = {1'b0, a} + b;
    return s > {1'b0, OFFSET_SAT} ? OFFSET_SAT : s[15:0];
  endfunction

endpackage

// File: hdl/ipth_field_tracker.sv
// ----------------------------------------------------------------------------
// ipth_field_tracker
// Holds the per-packet parse state, folds in one byte per step and forms the
// packet summary on the final byte.
// ----------------------------------------------------------------------------
module ipth_field_tracker #(
  parameter int MAX_PACKET_LEN = 65535
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [7:0]           data_byte,
  input  logic                 last_byte,
  output ipth_pkg::pkt_result_t result
);
  import ipth_pkg::*;

  localparam logic [15:0] MaxLen = MAX_PACKET_LEN[15:0];

  pkt_state_t st;
  pkt_state_t st_next;
  pkt_state_t s;

  always_comb begin
    logic [15:0] pos;
    logic [15:0] d;
    logic [15:0] len;
    logic [15:0] hl;
    logic        ok;
    logic [15:0] ip_len;
    logic [8:0]  ext_units;

    s         = st;
    pos       = st.byte_position;
    d         = 16'd0;
    ext_units = {1'b0, data_byte} + 9'd1;

    if (pos < MaxLen) begin
      if (pos == 16'd0) begin
        s.ip_version   = data_byte[7:4];
        s.header_words = data_byte[3:0];
        if (data_byte[7:4] == IP_V4) begin
          s.transport_offset = {10'd0, data_byte[3:0], 2'b00};
          s.chain_done       = 1'b1;
        end
      end
      if (s.ip_version == IP_V4) begin
        if (pos == 16'd2 || pos == 16'd3)
          s.total_length_field = {s.total_length_field[7:0], data_byte};
        if (pos == 16'd9)
          s.first_proto_byte = data_byte;
        if (pos >= 16'd12 && pos <= 16'd15)
          s.src_lo = {s.src_lo[55:0], data_byte};
        if (pos >= 16'd16 && pos <= 16'd19)
          s.dst_lo = {s.dst_lo[55:0], data_byte};
      end else if (s.ip_version == IP_V6) begin
        if (pos == 16'd4 || pos == 16'd5)
          s.total_length_field = {s.total_length_field[7:0], data_byte};
        if (pos == 16'd6) begin
          s.first_proto_byte = data_byte;
          s.next_header      = data_byte;
          s.transport_offset = V6_HDR_LEN;
          s.chain_done       = !is_skippable(data_byte);
        end
        if (pos >= 16'd8 && pos <= 16'd15)
          s.src_hi = {s.src_hi[55:0], data_byte};
        if (pos >= 16'd16 && pos <= 16'd23)
          s.src_lo = {s.src_lo[55:0], data_byte};
        if (pos >= 16'd24 && pos <= 16'd31)
          s.dst_hi = {s.dst_hi[55:0], data_byte};
        if (pos >= 16'd32 && pos <= 16'd39)
          s.dst_lo = {s.dst_lo[55:0], data_byte};
        // extension chain: length byte sits one past the next-header byte
        if (pos > 16'd6 && !s.chain_done) begin
          if (s.ext_pending && ({1'b0, pos} == {1'b0, s.transport_offset} + 17'd1)) begin
            s.transport_offset = sat_add(s.transport_offset,
                                         {5'd0, ext_units, 3'b000});
            s.ext_pending      = 1'b0;
            s.chain_done       = !is_skippable(s.next_header);
          end else if (!s.ext_pending && pos == s.transport_offset) begin
            if (is_len_ext(s.next_header)) begin
              s.next_header = data_byte;
              s.ext_pending = 1'b1;
            end else begin
              s.next_header      = data_byte;
              s.transport_offset = sat_add(s.transport_offset, 17'd8);
              s.chain_done       = !is_skippable(data_byte);
            end
          end
        end
      end
      if (s.chain_done && !s.ext_pending && pos >= s.transport_offset) begin
        d = pos - s.transport_offset;
        if (d < TCP_ACC_BYTES)
          s.tcp_field_accum = {s.tcp_field_accum[55:0], data_byte};
        if (d == TCP_FLAGS_POS)
          s.flags_hold = data_byte;
      end
      s.byte_position = pos + 16'd1;
    end

    // packet summary from the state including this byte
    len    = s.byte_position;
    hl     = {10'd0, s.header_words, 2'b00};
    ok     = 1'b0;
    ip_len = 16'd0;
    if (s.ip_version == IP_V4) begin
      ok = len >= V4_MIN_LEN && s.header_words >= V4_MIN_IHL && len >= hl &&
           s.first_proto_byte == PROTO_TCP && len >= hl + TCP_MIN_BYTES;
      ip_len = (s.total_length_field != 16'd0) ? s.total_length_field : len;
    end else if (s.ip_version == IP_V6) begin
      ok = len >= V6_MIN_LEN && s.chain_done && !s.ext_pending &&
           s.next_header == PROTO_TCP &&
           ({1'b0, s.transport_offset} + {1'b0, TCP_MIN_BYTES} <= {1'b0, len});
      ip_len = s.total_length_field + V6_HDR_LEN;
    end

    result = '0;
    if (ok) begin
      result.status      = STATUS_OK;
      result.is_ipv6     = (s.ip_version == IP_V6);
      result.src_addr_hi = result.is_ipv6 ? s.src_hi : 64'd0;
      result.src_addr_lo = result.is_ipv6 ? s.src_lo : {32'd0, s.src_lo[31:0]};
      result.dst_addr_hi = result.is_ipv6 ? s.dst_hi : 64'd0;
      result.dst_addr_lo = result.is_ipv6 ? s.dst_lo : {32'd0, s.dst_lo[31:0]};
      result.source_port = s.tcp_field_accum[63:48];
      result.dest_port   = s.tcp_field_accum[47:32];
      result.seq_number  = s.tcp_field_accum[31:0];
      result.tcp_flags   = s.flags_hold;
      result.ip_length   = ip_len;
    end else if ((s.ip_version == IP_V4 && len >= 16'd10 &&
                  s.first_proto_byte != PROTO_TCP) ||
                 (s.ip_version == IP_V6 && len >= 16'd7 &&
                  s.first_proto_byte != PROTO_TCP)) begin
      result.status = STATUS_NOT_TCP;
    end else begin
      result.status = STATUS_FAIL;
    end

    st_next = last_byte ? pkt_state_t'('0) : s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (step) begin
      st <= st_next;
    end
  end

endmodule

// File: hdl/ip_tcp_header_parser.sv
// ----------------------------------------------------------------------------
// ip_tcp_header_parser
// Streams an IPv4/IPv6 packet byte by byte and reports addresses, TCP ports,
// sequence number, flags and IP length once per packet.
// ----------------------------------------------------------------------------
// One byte is taken per clock, with no gaps between bytes or packets while
// the input is not held (see below). Each byte passes an input register,
// then the field tracker folds it into the packet state; on the byte marked
// last the summary, formed from the state including that byte, is loaded
// into the result register as that byte leaves the input register.
// The result register decouples the two sides, so bytes keep flowing while a
// summary waits; only a final byte arriving behind a still-stalled summary
// holds the input. Status is ok, not TCP, or parse failure, with all other
// fields zero unless ok. Bytes past MAX_PACKET_LEN are ignored.
module ip_tcp_header_parser #(
  parameter int MAX_PACKET_LEN = 65535
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [1:0]  status,
  output logic        is_ipv6,
  output logic [63:0] src_addr_hi,
  output logic [63:0] src_addr_lo,
  output logic [63:0] dst_addr_hi,
  output logic [63:0] dst_addr_lo,
  output logic [15:0] source_port,
  output logic [15:0] dest_port,
  output logic [31:0] seq_number,
  output logic [7:0]  tcp_flags,
  output logic [15:0] ip_length
);
  import ipth_pkg::*;

  logic        hold_valid;
  logic [7:0]  hold_byte;
  logic        hold_last;
  logic        hold_go;
  logic        res_free;
  pkt_result_t summary;
  pkt_result_t res;

  assign res_free  = !res_valid || !res_stall;
  assign hold_go   = hold_valid && (!hold_last || res_free);
  assign req_stall = hold_valid && !hold_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (req_valid && !req_stall) begin
      hold_valid <= 1'b1;
    end else if (hold_go) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      hold_byte <= data_byte;
      hold_last <= last_byte;
    end
  end

  ipth_field_tracker #(
    .MAX_PACKET_LEN(MAX_PACKET_LEN)
  ) u_tracker (
    .clk      (clk),
    .rst      (rst),
    .step     (hold_go),
    .data_byte(hold_byte),
    .last_byte(hold_last),
    .result   (summary)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (hold_go && hold_last) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (hold_go && hold_last) begin
      res <= summary;
    end
  end

  assign status      = res.status;
  assign is_ipv6     = res.is_ipv6;
  assign src_addr_hi = res.src_addr_hi;
  assign src_addr_lo = res.src_addr_lo;
  assign dst_addr_hi = res.dst_addr_hi;
  assign dst_addr_lo = res.dst_addr_lo;
  assign source_port = res.source_port;
  assign dest_port   = res.dest_port;
  assign seq_number  = res.seq_number;
  assign tcp_flags   = res.tcp_flags;
  assign ip_length   = res.ip_length;

endmodule
